// ----- hdl/bced_pkg.sv -----
// ----------------------------------------------------------------------------
// Button click event detector package
// Shared widths, register indexes, event codes and the structs that travel
// between the configuration registers, the event core and the top level.
// ----------------------------------------------------------------------------
package bced_pkg;

	// Width of the wide configuration values and of the write data port.
	localparam int CFG_W = 16;

	// Default width of the hold and release timers.
	localparam int TIMER_WIDTH_DEF = 16;

	// Number of event codes and width of the register index.
	localparam int EV_COUNT = 7;
	localparam int IDX_W    = 3;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_ACTIVE_LEVEL  = 3'd0,
		REG_SCAN_PERIOD   = 3'd1,
		REG_DEBOUNCE      = 3'd2,
		REG_LONG_HOLD     = 3'd3,
		REG_RELEASE_WAIT  = 3'd4,
		REG_HANDLER_MASK  = 3'd5
	} reg_idx_t;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] RST_SCAN_PERIOD  = 16'd1;
	localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd20;
	localparam logic [CFG_W-1:0] RST_LONG_HOLD    = 16'd1000;
	localparam logic [CFG_W-1:0] RST_RELEASE_WAIT = 16'd300;

	// Event codes reported on the result channel.
	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_DOWN       = 3'd1,
		EV_UP         = 3'd2,
		EV_SINGLE     = 3'd3,
		EV_DOUBLE     = 3'd4,
		EV_LONG_START = 3'd5,
		EV_LONG_END   = 3'd6
	} event_t;

	// Button state machine, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_PRESSED  = 5'b00010,
		ST_RELEASED = 5'b00100,
		ST_SECOND   = 5'b01000,
		ST_LONG     = 5'b10000
	} state_t;

	// Configuration as seen by the event core.
	typedef struct packed {
		logic                active_level;
		logic [CFG_W-1:0]    scan_period;
		logic [CFG_W-1:0]    debounce;
		logic [CFG_W-1:0]    long_hold;
		logic [CFG_W-1:0]    release_wait;
		logic [EV_COUNT-1:0] handler_mask;
	} cfg_t;

	// Result of one scan tick.
	typedef struct packed {
		event_t ev;
		logic   fired;
	} res_t;

endpackage

// ----- hdl/button_click_event_detector_top.sv -----
// ----------------------------------------------------------------------------
// Button click event detector top level
// Turns one sampled pin level per scan tick into button events.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on in_valid/in_ready carries button_level for one scan tick.
// Each input beat gives exactly one result beat on out_valid/out_ready with
// event_code (the last event assigned) and handler_fired.
// The sample is captured in an input register. When the output register is
// free, the state machine step runs and its result is loaded into the output
// register, which raises out_valid.
// Throughput is one beat per cycle while the receiver does not stall; the
// state update is combinational between the input and result registers.
// When the receiver stalls, the result holds in the output register, one
// more beat waits in the input register, and then in_ready drops.
// The user writes the configuration registers through wr_en/wr_index/wr_data
// only while no beat is in flight; the block itself does not enforce it.
// Reset clears both pipeline registers, puts the state machine in idle with
// both timers and the last event at zero, and loads the register defaults.
// ----------------------------------------------------------------------------
module button_click_event_detector_top
	import bced_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             button_level,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       event_code,
	output logic             handler_fired
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1, pin_s1;
	logic       advance;
	logic       out_valid_q;
	logic [2:0] event_q;
	logic       fired_q;

	// Configuration registers.
	bced_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// The input register moves on whenever the output register is free.
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= button_level;
		end
	end

	// Event state machine and timers.
	bced_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.pin    (pin_s1),
		.res    (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= res.ev;
			fired_q <= res.fired;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_code    = event_q;
	assign handler_fired = fired_q;

endmodule

// ----- hdl/bced_cfg.sv -----
// ----------------------------------------------------------------------------
// Button click event detector configuration registers
// Write-only register file; each register is loaded when the write enable
// is high and the index selects it. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module bced_cfg
	import bced_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level <= 1'b0;
			cfg_q.scan_period  <= RST_SCAN_PERIOD;
			cfg_q.debounce     <= RST_DEBOUNCE;
			cfg_q.long_hold    <= RST_LONG_HOLD;
			cfg_q.release_wait <= RST_RELEASE_WAIT;
			cfg_q.handler_mask <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_ACTIVE_LEVEL: cfg_q.active_level <= wr_data[0];
				REG_SCAN_PERIOD:  cfg_q.scan_period  <= wr_data;
				REG_DEBOUNCE:     cfg_q.debounce     <= wr_data;
				REG_LONG_HOLD:    cfg_q.long_hold    <= wr_data;
				REG_RELEASE_WAIT: cfg_q.release_wait <= wr_data;
				REG_HANDLER_MASK: cfg_q.handler_mask <= wr_data[EV_COUNT-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/bced_core.sv -----
// ----------------------------------------------------------------------------
// Button click event detector core
// Holds the button state machine, the hold and release timers and the last
// event. On each step it applies one pin sample and gives that tick's result.
// ----------------------------------------------------------------------------
module bced_core
	import bced_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	input  logic pin,
	output res_t res
);

	// Compare width covers both the timers and the thresholds.
	localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam int SW = CW + 1;

	state_t                 state_q, state_d;
	logic [TIMER_WIDTH-1:0] hold_q, hold_d, hold_inc;
	logic [TIMER_WIDTH-1:0] rel_q, rel_d, rel_inc;
	event_t                 last_q, ev_d;
	logic [SW-1:0]          hold_sum, rel_sum;
	logic                   pressed, assigned;
	logic                   hold_gt_deb, hold_gt_long, rel_gt_wait;
	logic [EV_COUNT:0]      mask_ext;

	// Saturating timer increments by the scan period.
	always_comb begin
		hold_sum = SW'(hold_q) + SW'(cfg.scan_period);
		rel_sum  = SW'(rel_q) + SW'(cfg.scan_period);
		hold_inc = (|hold_sum[SW-1:TIMER_WIDTH]) ? '1 : hold_sum[TIMER_WIDTH-1:0];
		rel_inc  = (|rel_sum[SW-1:TIMER_WIDTH]) ? '1 : rel_sum[TIMER_WIDTH-1:0];
	end

	// Threshold compares on the incremented timers.
	assign hold_gt_deb  = CW'(hold_inc) > CW'(cfg.debounce);
	assign hold_gt_long = CW'(hold_inc) > CW'(cfg.long_hold);
	assign rel_gt_wait  = CW'(rel_inc) > CW'(cfg.release_wait);
	assign pressed      = (pin == cfg.active_level);

	// Next state, timers and event for this tick.
	always_comb begin
		state_d  = state_q;
		hold_d   = hold_q;
		rel_d    = rel_q;
		ev_d     = last_q;
		assigned = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ev_d     = pressed ? EV_DOWN : EV_NONE;
				state_d  = pressed ? ST_PRESSED : ST_IDLE;
				assigned = 1'b1;
				hold_d   = '0;
				rel_d    = '0;
			end
			ST_PRESSED: begin
				hold_d = hold_inc;
				if (pressed) begin
					if (hold_gt_long) begin
						state_d  = ST_LONG;
						ev_d     = EV_LONG_START;
						assigned = 1'b1;
					end
				end else if (hold_gt_deb) begin
					state_d  = ST_RELEASED;
					ev_d     = EV_UP;
					assigned = 1'b1;
				end else begin
					state_d  = ST_IDLE;
					ev_d     = EV_NONE;
					assigned = 1'b1;
				end
			end
			ST_RELEASED: begin
				if (pressed) begin
					hold_d = hold_inc;
					if (hold_gt_deb) begin
						state_d  = ST_SECOND;
						ev_d     = EV_DOWN;
						assigned = 1'b1;
					end
				end else begin
					rel_d = rel_inc;
					if (rel_gt_wait) begin
						state_d  = ST_IDLE;
						ev_d     = EV_SINGLE;
						assigned = 1'b1;
					end
				end
			end
			ST_SECOND: begin
				if (pressed) begin
					hold_d = hold_inc;
				end else begin
					state_d  = ST_IDLE;
					ev_d     = EV_DOUBLE;
					assigned = 1'b1;
				end
			end
			ST_LONG: begin
				if (pressed) begin
					hold_d = hold_inc;
				end else begin
					// Long hold release reports only the long hold end.
					state_d  = ST_IDLE;
					ev_d     = EV_LONG_END;
					assigned = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// The mask is padded so that every 3-bit event code value has a bit.
	assign mask_ext  = {1'b0, cfg.handler_mask};
	assign res.ev    = ev_d;
	assign res.fired = assigned & mask_ext[ev_d];

	// State update on each applied tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hold_q  <= '0;
			rel_q   <= '0;
			last_q  <= EV_NONE;
		end else if (step) begin
			state_q <= state_d;
			hold_q  <= hold_d;
			rel_q   <= rel_d;
			last_q  <= ev_d;
		end
	end

endmodule

// ----- hdl/bced_checker.sv -----
// ----------------------------------------------------------------------------
// Button click event detector checker
// Port-level assertions on the result channel and the flow control.
// ----------------------------------------------------------------------------
module bced_checker
	import bced_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       button_level,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_code,
	input logic       handler_fired
);

	// A waiting input beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(button_level))
		else $error("input beat changed while waiting");

	// A stalled result beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code) && $stable(handler_fired))
		else $error("result beat changed while stalled");

	// A taken result frees the path, so the input side can always move.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the receiver is ready");

	// An empty output register never blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with the output register empty");

	// A result beat always carries a defined event code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= EV_LONG_END)
		else $error("undefined event code on a result beat");

endmodule

bind button_click_event_detector_top bced_checker u_bced_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.button_level  (button_level),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.event_code    (event_code),
	.handler_fired (handler_fired)
);

// ----- verif/button_click_event_detector_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button click event detector testbench
// Drives pin samples through the valid/ready input channel under a range of
// register settings, tracks the button state machine alongside the block and
// compares every event beat field by field against the tracked events.
// ----------------------------------------------------------------------------
module button_click_event_detector_top_test;
	import bced_pkg::*;

	localparam int TW          = TIMER_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 1100;
	localparam int MAX_REPORTS = 10;

	// Index past the last register; writes there must be ignored.
	localparam logic [IDX_W-1:0] SPARE_IDX = IDX_W'(int'(REG_HANDLER_MASK) + 1);

	// Tracks the button state machine and holds the events still to arrive.
	class click_scoreboard;
		logic                active_lvl;
		logic [CFG_W-1:0]    scan_step;
		logic [CFG_W-1:0]    debounce_lim;
		logic [CFG_W-1:0]    long_lim;
		logic [CFG_W-1:0]    release_lim;
		logic [EV_COUNT-1:0] handler_en;
		state_t              btn_state;
		logic [TW-1:0]       hold_t;
		logic [TW-1:0]       release_t;
		event_t              last_ev;
		res_t                pending_events[$];
		int                  errors;

		function new();
			active_lvl   = 1'b0;
			scan_step    = RST_SCAN_PERIOD;
			debounce_lim = RST_DEBOUNCE;
			long_lim     = RST_LONG_HOLD;
			release_lim  = RST_RELEASE_WAIT;
			handler_en   = '0;
			btn_state    = ST_IDLE;
			hold_t       = '0;
			release_t    = '0;
			last_ev      = EV_NONE;
			errors       = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_ACTIVE_LEVEL: active_lvl = d[0];
				REG_SCAN_PERIOD:  scan_step = d;
				REG_DEBOUNCE:     debounce_lim = d;
				REG_LONG_HOLD:    long_lim = d;
				REG_RELEASE_WAIT: release_lim = d;
				REG_HANDLER_MASK: handler_en = d[EV_COUNT-1:0];
				default: ;
			endcase
		endfunction

		// Timers grow by the scan period and stick at their top value.
		function logic [TW-1:0] bump(logic [TW-1:0] t);
			logic [TW:0] s;
			s = {1'b0, t} + {1'b0, scan_step};
			return s[TW] ? {TW{1'b1}} : s[TW-1:0];
		endfunction

		// One scan tick: advance the state machine and queue its event beat.
		function void predict_tick(logic pin);
			logic   pressed;
			logic   hit;
			event_t ev;
			res_t   r;
			pressed = (pin == active_lvl);
			hit     = 1'b0;
			ev      = last_ev;
			case (btn_state)
				ST_IDLE: begin
					ev = pressed ? EV_DOWN : EV_NONE;
					if (pressed)
						btn_state = ST_PRESSED;
					hit       = 1'b1;
					hold_t    = '0;
					release_t = '0;
				end
				ST_PRESSED: begin
					hold_t = bump(hold_t);
					if (pressed) begin
						if (hold_t > long_lim) begin
							btn_state = ST_LONG;
							ev        = EV_LONG_START;
							hit       = 1'b1;
						end
					end else if (hold_t > debounce_lim) begin
						btn_state = ST_RELEASED;
						ev        = EV_UP;
						hit       = 1'b1;
					end else begin
						btn_state = ST_IDLE;
						ev        = EV_NONE;
						hit       = 1'b1;
					end
				end
				ST_RELEASED: begin
					if (pressed) begin
						// The hold timer was never cleared, so it keeps counting.
						hold_t = bump(hold_t);
						if (hold_t > debounce_lim) begin
							btn_state = ST_SECOND;
							ev        = EV_DOWN;
							hit       = 1'b1;
						end
					end else begin
						release_t = bump(release_t);
						if (release_t > release_lim) begin
							btn_state = ST_IDLE;
							ev        = EV_SINGLE;
							hit       = 1'b1;
						end
					end
				end
				ST_SECOND: begin
					if (pressed) begin
						hold_t = bump(hold_t);
					end else begin
						btn_state = ST_IDLE;
						ev        = EV_DOUBLE;
						hit       = 1'b1;
					end
				end
				ST_LONG: begin
					if (pressed) begin
						hold_t = bump(hold_t);
					end else begin
						// Releasing a long hold reports only its end.
						btn_state = ST_IDLE;
						ev        = EV_LONG_END;
						hit       = 1'b1;
					end
				end
				default: ;
			endcase
			last_ev = ev;
			r.ev    = ev;
			r.fired = hit && handler_en[ev];
			pending_events.push_back(r);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_result(logic [2:0] code, logic fired);
			res_t r;
			if (pending_events.size() == 0) begin
				report($sformatf("unexpected event beat: event_code %0d handler_fired %0b",
					code, fired));
				return;
			end
			r = pending_events.pop_front();
			if (code !== r.ev || fired !== r.fired)
				report($sformatf({"event mismatch: event_code exp %0d got %0d, ",
					"handler_fired exp %0b got %0b"}, r.ev, code, r.fired, fired));
		endfunction

		function int pending();
			return pending_events.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;
	logic             in_valid;
	logic             in_ready;
	logic             button_level;
	logic             out_valid;
	logic             out_ready;
	logic [2:0]       event_code;
	logic             handler_fired;

	click_scoreboard sb = new();
	bit              quiet = 1'b0;
	int              cycles = 0;

	button_click_event_detector_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.button_level  (button_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_code    (event_code),
		.handler_fired (handler_fired)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver stalls now and then, except during the quiet stretch.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= quiet || ($urandom_range(0, 99) >= 8);
		end
	end

	// Every accepted event beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(event_code, handler_fired);
	end

	function automatic logic [CFG_W-1:0] reg_value(cfg_t c, reg_idx_t r);
		case (r)
			REG_ACTIVE_LEVEL: return {{(CFG_W-1){1'b0}}, c.active_level};
			REG_SCAN_PERIOD:  return c.scan_period;
			REG_DEBOUNCE:     return c.debounce;
			REG_LONG_HOLD:    return c.long_hold;
			REG_RELEASE_WAIT: return c.release_wait;
			default:          return {{(CFG_W-EV_COUNT){1'b0}}, c.handler_mask};
		endcase
	endfunction

	// Writes every register, one per cycle, starting and ending at a falling edge.
	task automatic load_cfg(input cfg_t c, input bit poke_spare);
		reg_idx_t         r;
		logic [CFG_W-1:0] junk;
		r = r.first();
		do begin
			wr_en    <= 1'b1;
			wr_index <= r;
			wr_data  <= reg_value(c, r);
			sb.write_reg(r, reg_value(c, r));
			@(negedge clk);
			r = r.next();
		end while (r != r.first());
		if (poke_spare) begin
			junk     = CFG_W'($urandom);
			wr_en    <= 1'b1;
			wr_index <= SPARE_IDX;
			wr_data  <= junk;
			sb.write_reg(SPARE_IDX, junk);
			@(negedge clk);
		end
		wr_en <= 1'b0;
	endtask

	// Sends one pin sample; called and returns at a falling edge.
	task automatic send_pin(input logic p);
		while (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		button_level <= p;
		do @(posedge clk); while (!in_ready);
		sb.predict_tick(p);
		@(negedge clk);
	endtask

	task automatic send_run(input logic p, input int n);
		repeat (n) send_pin(p);
	endtask

	// Drops valid and waits until every expected beat has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic cfg_t pick_cfg(int kind);
		cfg_t c;
		c.active_level = 1'($urandom_range(0, 1));
		c.handler_mask = EV_COUNT'($urandom);
		case (kind)
			0: begin
				c.scan_period  = CFG_W'($urandom);
				c.debounce     = CFG_W'($urandom);
				c.long_hold    = CFG_W'($urandom);
				c.release_wait = CFG_W'($urandom);
			end
			1: begin
				c.scan_period  = $urandom_range(0, 1) ? '1 : '0;
				c.debounce     = $urandom_range(0, 1) ? '1 : '0;
				c.long_hold    = $urandom_range(0, 1) ? '1 : '0;
				c.release_wait = $urandom_range(0, 1) ? '1 : '0;
			end
			default: begin
				c.scan_period  = CFG_W'($urandom_range(1, 4));
				c.debounce     = CFG_W'($urandom_range(0, 12));
				c.long_hold    = CFG_W'(int'(c.debounce) + int'($urandom_range(0, 40)));
				c.release_wait = CFG_W'($urandom_range(0, 30));
			end
		endcase
		return c;
	endfunction

	// Main stimulus.
	initial begin
		cfg_t c;
		int   phase;
		int   rand_items;
		int   budget;
		int   sent;
		int   step;
		int   hold_max;
		int   rel_max;
		int   la;
		int   lb;
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_index     = REG_ACTIVE_LEVEL;
		wr_data      = '0;
		in_valid     = 1'b0;
		button_level = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Register defaults: idle tick, press down, then a bounce that falls back to idle.
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 1);

		// Tight thresholds: single click, double click, long hold start and end.
		wait_drained();
		c = '{active_level: 1'b1, scan_period: 16'd1, debounce: 16'd0, long_hold: 16'd2,
			release_wait: 16'd1, handler_mask: 7'h7F};
		load_cfg(c, 1'b0);
		send_run(1'b1, 1);
		send_run(1'b0, 3);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 1);
		send_run(1'b0, 1);
		send_run(1'b1, 4);
		send_run(1'b0, 1);

		// Saturated timers; the second press counts at once off the old hold time.
		wait_drained();
		c = '{active_level: 1'b0, scan_period: 16'hFFFF, debounce: 16'hFFFE,
			long_hold: 16'hFFFF, release_wait: 16'hFFFF, handler_mask: 7'h2A};
		load_cfg(c, 1'b1);
		send_run(1'b0, 3);
		send_run(1'b1, 2);
		send_run(1'b0, 1);
		send_run(1'b1, 1);

		// Random phases: mostly press/release runs sized to the thresholds, some noise.
		phase      = 0;
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			wait_drained();
			c = pick_cfg((phase % 5 == 1) ? 0 : (phase % 5 == 3) ? 1 : 2);
			load_cfg(c, phase == 4);
			quiet    = (phase == 2);
			step     = (c.scan_period == 0) ? 1 : int'(c.scan_period);
			hold_max = int'(c.long_hold) / step + 3;
			rel_max  = int'(c.release_wait) / step + 3;
			if (hold_max > 50)
				hold_max = 50;
			if (rel_max > 50)
				rel_max = 50;
			budget = $urandom_range(60, 140);
			sent   = 0;
			while (sent < budget) begin
				if ($urandom_range(0, 99) < 85) begin
					la = $urandom_range(1, hold_max);
					lb = $urandom_range(1, rel_max);
					send_run(c.active_level, la);
					send_run(!c.active_level, lb);
					sent += la + lb;
				end else begin
					la = $urandom_range(1, 6);
					repeat (la) send_pin(1'($urandom_range(0, 1)));
					sent += la;
				end
			end
			rand_items += sent;
			phase++;
		end

		// Drain and let the pipeline settle before the verdict.
		quiet = 1'b0;
		wait_drained();
		repeat (4) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
